// ----- rtl/mbs_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, types and descriptors for the Modbus TCP register server.
package mbs_pkg;

    localparam int MAP_SIZE        = 60;
    localparam int MAX_FRAME       = 256;
    localparam int MIN_FRAME       = 12;
    localparam int MANY_DATA_START = 13;
    localparam int READ_LIMIT      = 123;
    localparam int HDR_BYTES       = 12;
    localparam int READ_HDR_BYTES  = 9;
    localparam int MBAP_PREFIX     = 6;
    localparam int Q_DEPTH         = 2;

    localparam int MAP_AW          = (MAP_SIZE > 1) ? $clog2(MAP_SIZE) : 1;
    localparam int CNT_W           = $clog2(MAP_SIZE + 1);
    localparam int FRAME_AW        = $clog2(MAX_FRAME);
    localparam int LEN_W           = FRAME_AW + 1;
    localparam int Q_AW            = $clog2(Q_DEPTH);
    localparam int FRAME_RAM_AW    = FRAME_AW + Q_AW;
    localparam int FRAME_RAM_DEPTH = MAX_FRAME * Q_DEPTH;
    localparam int HDR_IDX_W       = $clog2(HDR_BYTES);

    localparam int S_TDATA_W       = 8;
    localparam int TX_WORD_W       = 32;
    localparam int TX_COUNT_W      = 3;
    localparam int M_TDATA_W       = 40;
    localparam int M_PAD_W         = M_TDATA_W - TX_WORD_W - TX_COUNT_W;

    localparam logic [7:0] FN_READ         = 8'h03;
    localparam logic [7:0] FN_WRITE_ONE    = 8'h06;
    localparam logic [7:0] FN_WRITE_MANY   = 8'h10;
    localparam logic [7:0] WRITE_MANY_PDU  = 8'd6;

    typedef enum logic [1:0] {
        OP_READ,
        OP_WRITE_ONE,
        OP_WRITE_MANY
    } op_t;

    typedef logic [HDR_BYTES-1:0][7:0] hdr_t;

    typedef struct packed {
        op_t               op;
        logic [Q_AW-1:0]   bank;
        logic [LEN_W-1:0]  n;
        logic [MAP_AW-1:0] start;
        hdr_t              hdr;
    } desc_t;

    typedef struct packed {
        logic                    we;
        logic [FRAME_RAM_AW-1:0] addr;
        logic [7:0]              data;
    } fwr_t;

endpackage

// ----- rtl/mbs_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module mbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/mbs_front.sv -----
`timescale 1ns / 1ps
// Front end: buffers frame bytes, captures the header and classifies each frame.
module mbs_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [7:0]     s_tdata,
    input  logic           s_tlast,
    input  logic           q_full,
    output logic           push,
    output mbs_pkg::desc_t push_desc,
    output mbs_pkg::fwr_t  fwr
);
    import mbs_pkg::*;

    logic [LEN_W-1:0] len_reg, len_next;
    logic             ovf_reg, ovf_next;
    logic [Q_AW-1:0]  bank_reg, bank_next;
    hdr_t             hdr_reg, hdr_next;
    logic             accept;
    logic             store;
    logic [LEN_W-1:0] len_inc;
    logic [7:0]       fc;
    logic [15:0]      start16;
    logic             known;
    op_t              op;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign store    = !ovf_reg && (len_reg < LEN_W'(MAX_FRAME));
    assign len_inc  = len_reg + LEN_W'(1);

    always_comb
    begin
        hdr_next = hdr_reg;
        if (accept && store && (len_reg < LEN_W'(HDR_BYTES)))
        begin
            hdr_next[len_reg[HDR_IDX_W-1:0]] = s_tdata;
        end
    end

    assign fc      = hdr_next[7];
    assign start16 = {hdr_next[8], hdr_next[9]};

    always_comb
    begin
        known = 1'b1;
        op    = OP_READ;
        unique case (fc)
            FN_READ:       op = OP_READ;
            FN_WRITE_ONE:  op = OP_WRITE_ONE;
            FN_WRITE_MANY: op = OP_WRITE_MANY;
            default:       known = 1'b0;
        endcase
    end

    always_comb
    begin
        len_next  = len_reg;
        ovf_next  = ovf_reg;
        bank_next = bank_reg;
        push      = 1'b0;
        fwr.we    = 1'b0;
        fwr.addr  = {bank_reg, len_reg[FRAME_AW-1:0]};
        fwr.data  = s_tdata;
        if (accept)
        begin
            if (store)
            begin
                fwr.we   = 1'b1;
                len_next = len_inc;
            end
            else
            begin
                ovf_next = 1'b1;
            end
            if (s_tlast)
            begin
                len_next = '0;
                ovf_next = 1'b0;
                if (store && known && (len_inc >= LEN_W'(MIN_FRAME))
                    && (start16 < 16'(MAP_SIZE)))
                begin
                    push      = 1'b1;
                    bank_next = bank_reg + Q_AW'(1);
                end
            end
        end
    end

    assign push_desc.op    = op;
    assign push_desc.bank  = bank_reg;
    assign push_desc.n     = len_inc;
    assign push_desc.start = start16[MAP_AW-1:0];
    assign push_desc.hdr   = hdr_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            ovf_reg  <= 1'b0;
            bank_reg <= '0;
        end
        else
        begin
            len_reg  <= len_next;
            ovf_reg  <= ovf_next;
            bank_reg <= bank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hdr_reg <= hdr_next;
    end

endmodule

// ----- rtl/mbs_queue.sv -----
`timescale 1ns / 1ps
// Short descriptor queue between the front end and the response engine.
module mbs_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mbs_pkg::desc_t push_desc,
    output logic           full,
    output logic           valid,
    output mbs_pkg::desc_t head,
    input  logic           pop
);
    import mbs_pkg::*;

    desc_t           entry_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_AW:0]   count_reg, count_next;

    assign full  = (count_reg == (Q_AW + 1)'(Q_DEPTH));
    assign valid = (count_reg != '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + Q_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + Q_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + (Q_AW + 1)'(1);
            2'b01:   count_next = count_reg - (Q_AW + 1)'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

// ----- rtl/mbs_back.sv -----
`timescale 1ns / 1ps
// Response engine: updates the register map and packs reply bytes into words.
module mbs_back (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   q_valid,
    input  mbs_pkg::desc_t                         head,
    output logic                                   pop,
    output logic [mbs_pkg::FRAME_RAM_AW-1:0]       frd_addr,
    input  logic [7:0]                             frd_data,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [mbs_pkg::M_TDATA_W-1:0]          m_tdata,  // tx_word, tx_count, zero pad
    output logic                                   m_tlast
);
    import mbs_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SETUP  = 6'b000010,
        S_WPRIME = 6'b000100,
        S_WRITE  = 6'b001000,
        S_PRIME  = 6'b010000,
        S_EMIT   = 6'b100000
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    hdr_t                   hout_reg, hout_next;
    logic [CNT_W:0]         q_reg, q_next;
    logic [7:0]             hi_reg, hi_next;
    logic [LEN_W-1:0]       p_reg, p_next;
    logic [TX_WORD_W-1:0]   pack_reg, pack_next;
    logic [1:0]             pack_n_reg, pack_n_next;
    logic                   ov_reg, ov_next;
    logic [TX_WORD_W-1:0]   ow_reg, ow_next;
    logic [TX_COUNT_W-1:0]  oc_reg, oc_next;
    logic                   ol_reg, ol_next;
    logic [MAP_SIZE-1:0]    mvalid_reg, mvalid_next;
    logic                   mv_reg;

    logic                   map_we;
    logic [MAP_AW-1:0]      map_waddr;
    logic [15:0]            map_wdata;
    logic [MAP_AW-1:0]      map_raddr;
    logic [15:0]            map_rdata;

    logic [15:0]            cnt16, room16, avail16, lim16, c16;
    logic [CNT_W-1:0]       c;
    logic [CNT_W:0]         c2;
    logic [LEN_W-1:0]       rd_len, pdu;
    hdr_t                   hset;

    logic [15:0]            map_word;
    logic [7:0]             map_byte;
    logic [7:0]             cur_byte;
    logic                   use_frame, use_hdr;
    logic                   is_last, complete, adv;
    logic [TX_WORD_W-1:0]   byte_pos;
    logic [LEN_W-1:0]       p_f;
    logic [LEN_W-1:0]       midx;
    logic [FRAME_AW-1:0]    f_lo;
    logic [CNT_W:0]         q_end;

    mbs_ram #(
        .WIDTH (16),
        .DEPTH (MAP_SIZE)
    ) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    always_comb
    begin
        cnt16   = {head.hdr[10], head.hdr[11]};
        room16  = 16'(MAP_SIZE) - 16'(head.start);
        avail16 = '0;
        if (head.n >= LEN_W'(MANY_DATA_START + 2))
        begin
            avail16 = 16'((head.n - LEN_W'(MANY_DATA_START)) >> 1);
        end
        lim16 = room16;
        if (head.op == OP_READ)
        begin
            if (lim16 > 16'(READ_LIMIT))
            begin
                lim16 = 16'(READ_LIMIT);
            end
        end
        else if (lim16 > avail16)
        begin
            lim16 = avail16;
        end
        c16    = (cnt16 < lim16) ? cnt16 : lim16;
        c      = c16[CNT_W-1:0];
        c2     = {c, 1'b0};
        rd_len = LEN_W'(READ_HDR_BYTES) + LEN_W'(c2);
        pdu    = rd_len - LEN_W'(MBAP_PREFIX);
    end

    always_comb
    begin
        hset = '0;
        unique case (head.op)
            OP_READ:
            begin
                hset[0] = head.hdr[0];
                hset[1] = head.hdr[1];
                hset[2] = head.hdr[2];
                hset[3] = head.hdr[3];
                hset[4] = 8'(pdu >> 8);
                hset[5] = pdu[7:0];
                hset[7] = FN_READ;
                hset[8] = 8'(c2);
            end
            OP_WRITE_MANY:
            begin
                hset[0]  = head.hdr[0];
                hset[1]  = head.hdr[1];
                hset[2]  = head.hdr[2];
                hset[3]  = head.hdr[3];
                hset[4]  = head.hdr[4];
                hset[5]  = WRITE_MANY_PDU;
                hset[6]  = head.hdr[6];
                hset[7]  = FN_WRITE_MANY;
                hset[8]  = head.hdr[8];
                hset[9]  = head.hdr[9];
                hset[10] = head.hdr[10];
                hset[11] = head.hdr[11];
            end
            default:
            begin
                hset = '0;
            end
        endcase
    end

    assign map_word  = mv_reg ? map_rdata : 16'h0000;
    assign map_byte  = p_reg[0] ? map_word[15:8] : map_word[7:0];
    assign use_frame = (head.op == OP_WRITE_ONE);
    assign use_hdr   = !use_frame
                       && ((head.op == OP_WRITE_MANY) || (p_reg < LEN_W'(READ_HDR_BYTES)));
    assign cur_byte  = use_frame ? frd_data
                     : (use_hdr ? hout_reg[p_reg[HDR_IDX_W-1:0]] : map_byte);
    assign is_last   = (p_reg == len_reg - LEN_W'(1));
    assign complete  = (pack_n_reg == 2'd3) || is_last;
    assign adv       = !(complete && ov_reg && !m_tready);
    assign q_end     = {cnt_reg, 1'b0} - (CNT_W + 1)'(1);

    always_comb
    begin
        unique case (pack_n_reg)
            2'd0: byte_pos = {cur_byte, 24'h000000};
            2'd1: byte_pos = {8'h00, cur_byte, 16'h0000};
            2'd2: byte_pos = {16'h0000, cur_byte, 8'h00};
            2'd3: byte_pos = {24'h000000, cur_byte};
            default: byte_pos = '0;
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        len_next    = len_reg;
        hout_next   = hout_reg;
        q_next      = q_reg;
        hi_next     = hi_reg;
        p_next      = p_reg;
        pack_next   = pack_reg;
        pack_n_next = pack_n_reg;
        ov_next     = ov_reg && !m_tready;
        ow_next     = ow_reg;
        oc_next     = oc_reg;
        ol_next     = ol_reg;
        pop         = 1'b0;
        map_we      = 1'b0;
        map_waddr   = head.start;
        map_wdata   = {head.hdr[10], head.hdr[11]};
        p_f         = '0;
        f_lo        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                cnt_next  = c;
                hout_next = hset;
                unique case (head.op)
                    OP_READ:       len_next = rd_len;
                    OP_WRITE_MANY: len_next = LEN_W'(HDR_BYTES);
                    default:       len_next = head.n;
                endcase
                if (head.op == OP_WRITE_ONE)
                begin
                    map_we = 1'b1;
                end
                if ((head.op == OP_WRITE_MANY) && (c != '0))
                begin
                    state_next = S_WPRIME;
                end
                else
                begin
                    state_next = S_PRIME;
                end
            end
            S_WPRIME:
            begin
                f_lo       = FRAME_AW'(MANY_DATA_START);
                q_next     = '0;
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                f_lo = FRAME_AW'(LEN_W'(MANY_DATA_START) + LEN_W'(q_reg) + LEN_W'(1));
                if (!q_reg[0])
                begin
                    hi_next = frd_data;
                end
                else
                begin
                    map_we    = 1'b1;
                    map_waddr = MAP_AW'(LEN_W'(head.start) + LEN_W'(q_reg >> 1));
                    map_wdata = {hi_reg, frd_data};
                end
                if (q_reg == q_end)
                begin
                    state_next = S_PRIME;
                end
                else
                begin
                    q_next = q_reg + (CNT_W + 1)'(1);
                end
            end
            S_PRIME:
            begin
                p_next      = '0;
                pack_next   = '0;
                pack_n_next = '0;
                state_next  = S_EMIT;
            end
            S_EMIT:
            begin
                p_f  = adv ? p_reg + LEN_W'(1) : p_reg;
                f_lo = p_f[FRAME_AW-1:0];
                if (adv)
                begin
                    if (complete)
                    begin
                        ov_next     = 1'b1;
                        ow_next     = pack_reg | byte_pos;
                        oc_next     = TX_COUNT_W'(pack_n_reg) + TX_COUNT_W'(1);
                        ol_next     = is_last;
                        pack_next   = '0;
                        pack_n_next = '0;
                    end
                    else
                    begin
                        pack_next   = pack_reg | byte_pos;
                        pack_n_next = pack_n_reg + 2'd1;
                    end
                    if (is_last)
                    begin
                        pop        = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        p_next = p_f;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign midx      = (p_f - LEN_W'(READ_HDR_BYTES)) >> 1;
    assign map_raddr = MAP_AW'(LEN_W'(head.start) + midx);
    assign frd_addr  = {head.bank, f_lo};

    always_comb
    begin
        mvalid_next = mvalid_reg;
        if (map_we)
        begin
            mvalid_next[map_waddr] = 1'b1;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, oc_reg, ow_reg};
    assign m_tlast  = ol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ov_reg     <= 1'b0;
            mvalid_reg <= '0;
            pack_n_reg <= '0;
            mv_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ov_reg     <= ov_next;
            mvalid_reg <= mvalid_next;
            pack_n_reg <= pack_n_next;
            mv_reg     <= (map_raddr < MAP_AW'(MAP_SIZE - 1)) || (map_raddr == MAP_AW'(MAP_SIZE - 1))
                          ? mvalid_reg[map_raddr] : 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        len_reg  <= len_next;
        hout_reg <= hout_next;
        q_reg    <= q_next;
        hi_reg   <= hi_next;
        p_reg    <= p_next;
        pack_reg <= pack_next;
        ow_reg   <= ow_next;
        oc_reg   <= oc_next;
        ol_reg   <= ol_next;
    end

endmodule

// ----- rtl/modbus_tcp_register_server_top.sv -----
`timescale 1ns / 1ps
// After the last frame byte the descriptor is queued; the response engine then steps through
// S_IDLE, S_SETUP and S_PRIME to the first byte packed in S_EMIT, via S_WPRIME and S_WRITE
// when a multiple write stores any register; each word leaves through the output register.
// Throughput: input takes one byte per cycle while fewer than two decoded frames wait;
// the response engine packs one byte per cycle unless a full word waits on a stalled output.
// Reset clears all control state and marks every holding register as zero; no clearing pass.
module modbus_tcp_register_server_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [mbs_pkg::S_TDATA_W-1:0] s_tdata,   // rx_byte
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mbs_pkg::M_TDATA_W-1:0] m_tdata,   // tx_word, tx_count, zero pad
    output logic                          m_tlast
);
    import mbs_pkg::*;

    logic                    push;
    desc_t                   push_desc;
    fwr_t                    fwr;
    logic                    q_full;
    logic                    q_valid;
    desc_t                   head;
    logic                    pop;
    logic [FRAME_RAM_AW-1:0] frd_addr;
    logic [7:0]              frd_data;

    mbs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .q_full    (q_full),
        .push      (push),
        .push_desc (push_desc),
        .fwr       (fwr)
    );

    mbs_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_RAM_DEPTH)
    ) u_frame_ram (
        .clk   (clk),
        .we    (fwr.we),
        .waddr (fwr.addr),
        .wdata (fwr.data),
        .raddr (frd_addr),
        .rdata (frd_data)
    );

    mbs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .full      (q_full),
        .valid     (q_valid),
        .head      (head),
        .pop       (pop)
    );

    mbs_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .head     (head),
        .pop      (pop),
        .frd_addr (frd_addr),
        .frd_data (frd_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- rtl/mbs_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the register server, bound to the top level.
module mbs_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [mbs_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tlast
);
    import mbs_pkg::*;

    logic [TX_COUNT_W-1:0] cnt;

    assign cnt = m_tdata[TX_WORD_W +: TX_COUNT_W];

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output transaction changed while stalled");

    a_full_word: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> cnt == TX_COUNT_W'(4))
        else $error("non-final word not full");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (cnt != '0) && (cnt <= TX_COUNT_W'(4)))
        else $error("byte count out of range");

    a_zero_tail: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (cnt != TX_COUNT_W'(1) || m_tdata[23:0] == 24'h0)
                  && (cnt != TX_COUNT_W'(2) || m_tdata[15:0] == 16'h0)
                  && (cnt != TX_COUNT_W'(3) || m_tdata[7:0] == 8'h0))
        else $error("unused byte lanes not zero");

    a_reset_idle: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("output valid right after reset");

endmodule

bind modbus_tcp_register_server_top mbs_checker u_mbs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
